FILE: design/vlbp_pkg.sv
// Package for the variable-length bit packer: function codes and the control
// record passed from the merge stage to the byte output stage. No dependencies.
`timescale 1ns / 1ps

package vlbp_pkg;

  // Function codes carried by the func field of an input word
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_FLUSH  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam int unsigned BYTE_BITS = 8;
  // One item never spans more than this many field bits
  localparam int unsigned FIELD_LIMIT = 33;

  // Bytes produced by one item and the meaningful bits of each of them
  typedef struct packed {
    logic [2:0] nbytes;
    logic [3:0] vbits;
  } pack_ctl_t;

endpackage

FILE: design/vlbp_item_if.sv
// Input channel of the bit packer: valid/ready handshake plus one code word.
// Depends on nothing.
`timescale 1ns / 1ps

interface vlbp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] code_value;
  logic [5:0]  code_len;
  logic [5:0]  field_width;

  modport source (output valid, output func, output code_value, output code_len,
                  output field_width, input ready);
  modport sink (input valid, input func, input code_value, input code_len,
                input field_width, output ready);
endinterface

FILE: design/vlbp_result_if.sv
// Output channel of the bit packer: valid/ready handshake plus one packed byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface vlbp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] valid_bits;
  logic       last;

  modport source (output valid, output out_byte, output valid_bits, output last,
                  input ready);
  modport sink (input valid, input out_byte, input valid_bits, input last,
                output ready);
endinterface

FILE: design/variable_length_bit_packer.sv
// Variable-length bit packer, most significant bit first.
// Each accepted item moves into the byte shifter, then byte by byte into the output
// byte register. Throughput: one item per cycle while each item yields at most one
// byte with no output stall; a longer item (up to five bytes) holds the shifter.
// Reset (synchronous, active high) empties the leftover byte and both stages.
`timescale 1ns / 1ps

module variable_length_bit_packer #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  vlbp_item_if.sink       item,
  vlbp_result_if.source   result
);

  localparam int LIMIT = (MAX_CODE_BITS > vlbp_pkg::FIELD_LIMIT) ?
                         vlbp_pkg::FIELD_LIMIT : MAX_CODE_BITS;
  localparam int ACC_W = LIMIT + 7;

  logic [ACC_W-1:0]    m_word;
  vlbp_pkg::pack_ctl_t m_ctl;
  logic                accept;

  // Byte shifter stage
  logic [ACC_W-1:0]    a_word;
  logic [2:0]          a_cnt;
  logic [3:0]          a_vbits;
  logic                a_move;

  // Output byte register
  logic                b_valid;
  logic [7:0]          b_byte;
  logic [3:0]          b_vbits;
  logic                b_last;
  logic                b_free;

  assign b_free     = !b_valid || result.ready;
  assign a_move     = (a_cnt != 3'd0) && b_free;
  assign item.ready = (a_cnt == 3'd0) || ((a_cnt == 3'd1) && b_free);
  assign accept     = item.valid && item.ready;

  vlbp_merge #(
    .LIMIT (LIMIT),
    .ACC_W (ACC_W)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .take        (accept),
    .func        (item.func),
    .code_value  (item.code_value),
    .code_len    (item.code_len),
    .field_width (item.field_width),
    .word        (m_word),
    .ctl         (m_ctl)
  );

  // Load a merged word, or advance one byte toward the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_cnt <= '0;
    end else if (accept) begin
      a_cnt <= m_ctl.nbytes;
    end else if (a_move) begin
      a_cnt <= a_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_word  <= m_word;
      a_vbits <= m_ctl.vbits;
    end else if (a_move) begin
      a_word <= a_word << 8;
    end
  end

  // Hold the offered byte until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_move;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_byte  <= a_word[ACC_W-1 -: 8];
      b_vbits <= a_vbits;
      b_last  <= (a_cnt == 3'd1);
    end
  end

  assign result.valid      = b_valid;
  assign result.out_byte   = b_byte;
  assign result.valid_bits = b_vbits;
  assign result.last       = b_last;

endmodule

FILE: design/vlbp_merge.sv
// Merge stage: holds the leftover partial byte and merges each incoming code
// into a left-aligned word of whole bytes. Depends on vlbp_pkg.
`timescale 1ns / 1ps

module vlbp_merge #(
  parameter int LIMIT = 32,
  parameter int ACC_W = 39
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [1:0]           func,
  input  logic [31:0]          code_value,
  input  logic [5:0]           code_len,
  input  logic [5:0]           field_width,
  output logic [ACC_W-1:0]     word,
  output vlbp_pkg::pack_ctl_t  ctl
);

  localparam logic [5:0] LIM6 = 6'(LIMIT);
  localparam logic [6:0] ACC7 = 7'(ACC_W);

  logic [6:0]  partial_bits, partial_bits_next;
  logic [2:0]  partial_count, partial_count_next;

  logic [5:0]  len, wid, wid_eff;
  logic [32:0] mask33, value_m;
  logic [63:0] acc64, left64, flush64;
  logic [6:0]  total;
  logic [2:0]  rem;
  logic [6:0]  keep;

  // Saturate the lengths and raise the field width to the code length
  assign len     = (code_len > LIM6) ? LIM6 : code_len;
  assign wid     = (field_width > LIM6) ? LIM6 : field_width;
  assign wid_eff = (wid < len) ? len : wid;

  // Drop code bits above the code length
  assign mask33  = (33'd1 << len) - 33'd1;
  assign value_m = {1'b0, code_value} & mask33;

  // Append the field behind the held bits, then left-align the whole word
  assign acc64  = ({57'd0, partial_bits} << wid_eff) | {31'd0, value_m};
  assign total  = {4'd0, partial_count} + {1'b0, wid_eff};
  assign left64 = acc64 << (ACC7 - total);
  assign rem    = total[2:0];
  assign keep   = acc64[6:0] & ((7'd1 << rem) - 7'd1);

  // Left-align the held bits for a flush
  assign flush64 = {57'd0, partial_bits} << (ACC7 - {4'd0, partial_count});

  // Select the word, byte count and next leftover per function
  always_comb begin
    word               = left64[ACC_W-1:0];
    ctl.nbytes         = 3'(total >> 3);
    ctl.vbits          = 4'(vlbp_pkg::BYTE_BITS);
    partial_bits_next  = partial_bits;
    partial_count_next = partial_count;
    case (func)
      vlbp_pkg::FUNC_APPEND: begin
        partial_bits_next  = keep;
        partial_count_next = rem;
      end
      vlbp_pkg::FUNC_FLUSH: begin
        word               = flush64[ACC_W-1:0];
        ctl.nbytes         = (partial_count != 3'd0) ? 3'd1 : 3'd0;
        ctl.vbits          = {1'b0, partial_count};
        partial_bits_next  = '0;
        partial_count_next = '0;
      end
      vlbp_pkg::FUNC_CLEAR: begin
        ctl.nbytes         = 3'd0;
        partial_bits_next  = '0;
        partial_count_next = '0;
      end
      default: begin
        ctl.nbytes = 3'd0;
      end
    endcase
  end

  // Update the leftover on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_bits  <= '0;
      partial_count <= '0;
    end else if (take) begin
      partial_bits  <= partial_bits_next;
      partial_count <= partial_count_next;
    end
  end

endmodule
